// ===== sv/square_matrix_multiply_engine_top_defines.svh =====
// Assertion macros for the square matrix multiply engine.
// Included by the RTL file that carries concurrent checks; no dependencies.
`ifndef SQUARE_MATRIX_MULTIPLY_ENGINE_TOP_DEFINES_SVH
`define SQUARE_MATRIX_MULTIPLY_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTH
// check at every edge outside reset
`define SMME_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("smme assertion failed");
// check at every edge, reset included
`define SMME_ASSERT_RST(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("smme reset assertion failed");
`else
`define SMME_ASSERT(lbl, clk, rstn, prop)
`define SMME_ASSERT_RST(lbl, clk, prop)
`endif

`endif

// ===== sv/smme_pkg.sv =====
// Shared types and constants of the square matrix multiply engine.
// No dependencies; imported by smme_mac and the top level.
`timescale 1ns / 1ps
`default_nettype none

package smme_pkg;

	localparam int DEF_MAX_DIM    = 64;
	localparam int DEF_VALUE_BITS = 16;

	localparam int SIZE_W    = 7;
	localparam int INDEX_W   = 6;
	localparam int VALUE_W   = 16;
	localparam int PRODUCT_W = 38;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

	typedef enum logic [1:0] {
		REQ_LOAD_A  = 2'd0,
		REQ_LOAD_B  = 2'd1,
		REQ_COMPUTE = 2'd2,
		REQ_READ    = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_COMPUTE,
		ST_DRAIN
	} state_t;

	// control that travels with one multiply-accumulate step
	typedef struct packed {
		logic vld;
		logic last;
	} mac_ctl_t;

endpackage

`default_nettype wire

// ===== sv/smme_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module smme_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== sv/smme_mac.sv =====
// Multiply-accumulate datapath: registered product, 38-bit accumulator and C write-back.
// Depends on smme_pkg.
`timescale 1ns / 1ps
`default_nettype none

module smme_mac
	import smme_pkg::*;
#(
	parameter int VALUE_BITS = DEF_VALUE_BITS,
	parameter int ADDR_W     = 12
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire mac_ctl_t              ctl_s1,
	input  wire logic [ADDR_W-1:0]     caddr_s1,
	input  wire logic [VALUE_BITS-1:0] a_data,
	input  wire logic [VALUE_BITS-1:0] b_data,
	output logic                       c_we,
	output logic      [ADDR_W-1:0]     c_waddr,
	output logic      [PRODUCT_W-1:0]  c_wdata
);

	localparam int MULT_W = 2 * VALUE_BITS;

	mac_ctl_t             ctl_s2;
	logic [ADDR_W-1:0]    caddr_s2;
	logic [MULT_W-1:0]    mult_s2;
	logic [PRODUCT_W-1:0] mult_ext;
	logic [PRODUCT_W-1:0] acc_q;
	logic [PRODUCT_W-1:0] sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		mult_s2  <= MULT_W'(a_data) * MULT_W'(b_data);
		caddr_s2 <= caddr_s1;
	end

	generate
		if (MULT_W >= PRODUCT_W) begin : g_trunc
			assign mult_ext = mult_s2[PRODUCT_W-1:0];
		end else begin : g_ext
			assign mult_ext = {{(PRODUCT_W-MULT_W){1'b0}}, mult_s2};
		end
	endgenerate

	// wraps modulo 2^38
	assign sum = acc_q + mult_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (ctl_s2.vld) begin
			// restart the sum after the last term of an element
			acc_q <= ctl_s2.last ? '0 : sum;
		end
	end

	assign c_we    = ctl_s2.vld & ctl_s2.last;
	assign c_waddr = caddr_s2;
	assign c_wdata = sum;

endmodule

`default_nettype wire

// ===== sv/square_matrix_multiply_engine_top.sv =====
// Top level of the square matrix multiply engine: A, B and C stores, sequencer, output register.
// Depends on smme_pkg, smme_ram, smme_mac and the assertion macro header.
//
//  channel | signals                                      | direction
//  --------+----------------------------------------------+----------
//  in      | in_valid, in_stall, req_type, row, col, value | to block
//  out     | out_valid, out_stall, product                 | from block
//  cfg     | cfg_wr_en, cfg_wr_data (matrix_size)          | to block
//
// A load is written to its store when it is accepted. A read goes through the registered C
// store read and waits in the read state while the output register stays stalled. A compute
// issues one multiply-accumulate per cycle, bound by the single read port of the A and B stores.
// C is not swept on compute; reads outside the last computed region return zero.
// Reset clears control only; the stores hold garbage until written.
`timescale 1ns / 1ps
`default_nettype none
`include "square_matrix_multiply_engine_top_defines.svh"

module square_matrix_multiply_engine_top
	import smme_pkg::*;
#(
	parameter int MAX_DIM    = DEF_MAX_DIM,
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [SIZE_W-1:0]    cfg_wr_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           req_type,
	input  wire logic [INDEX_W-1:0]   row,
	input  wire logic [INDEX_W-1:0]   col,
	input  wire logic [VALUE_W-1:0]   value,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic      [PRODUCT_W-1:0] product
);

	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int IDX_W  = $clog2(MAX_DIM);
	localparam int DIM_W  = $clog2(MAX_DIM + 1);

	logic [SIZE_W-1:0]    size_q;
	logic [DIM_W-1:0]     active_dim;
	logic [DIM_W-1:0]     n_q;
	logic [DIM_W-1:0]     nm1;
	logic [DIM_W-1:0]     last_dim_q;
	state_t               state_q;
	state_t               state_d;
	logic                 in_acc;
	req_t                 req;
	logic                 in_store;
	logic [ADDR_W-1:0]    in_addr;
	logic [VALUE_BITS-1:0] value_m;
	logic                 start_compute;
	logic                 out_load;
	logic                 zero_q;
	logic                 out_valid_q;
	logic [PRODUCT_W-1:0] product_q;

	logic [IDX_W-1:0]     i_q;
	logic [IDX_W-1:0]     j_q;
	logic [IDX_W-1:0]     k_q;
	logic                 k_last;
	logic                 j_last;
	logic                 i_last;
	logic                 issue;
	logic                 iter_ok;
	logic [ADDR_W-1:0]    a_raddr;
	logic [ADDR_W-1:0]    b_raddr;
	logic [ADDR_W-1:0]    c_addr_issue;
	mac_ctl_t             s1_ctl;
	logic [ADDR_W-1:0]    caddr_s1;

	logic [VALUE_BITS-1:0] a_rdata;
	logic [VALUE_BITS-1:0] b_rdata;
	logic [PRODUCT_W-1:0]  c_rdata;
	logic                  c_we;
	logic [ADDR_W-1:0]     c_waddr;
	logic [PRODUCT_W-1:0]  c_wdata;

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SIZE_RESET;
		end else if (cfg_wr_en) begin
			size_q <= cfg_wr_data;
		end
	end

	always_comb begin
		if (size_q == '0) begin
			active_dim = DIM_W'(1);
		end else if (int'(size_q) > MAX_DIM) begin
			active_dim = DIM_W'(MAX_DIM);
		end else begin
			active_dim = DIM_W'(size_q);
		end
	end

	// ---------------- input decode ----------------
	assign in_acc   = in_valid & ~in_stall;
	assign req      = req_t'(req_type);
	assign in_store = (int'(row) < MAX_DIM) && (int'(col) < MAX_DIM);
	assign in_addr  = ADDR_W'(ADDR_W'(row) * ADDR_W'(MAX_DIM) + ADDR_W'(col));

	generate
		if (VALUE_BITS <= VALUE_W) begin : g_val_trunc
			assign value_m = value[VALUE_BITS-1:0];
		end else begin : g_val_ext
			assign value_m = {{(VALUE_BITS-VALUE_W){1'b0}}, value};
		end
	endgenerate

	// ---------------- sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		in_stall      = 1'b1;
		start_compute = 1'b0;
		out_load      = 1'b0;
		issue         = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					case (req)
						REQ_COMPUTE: begin
							start_compute = 1'b1;
							state_d       = ST_COMPUTE;
						end
						REQ_READ: state_d = ST_READ;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_READ: begin
				// hold the RAM data until the output register frees up
				if (!out_valid_q || !out_stall) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_COMPUTE: begin
				issue = 1'b1;
				if (k_last && j_last && i_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!s1_ctl.vld) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------- loop counters ----------------
	assign nm1    = n_q - DIM_W'(1);
	assign k_last = DIM_W'(k_q) == nm1;
	assign j_last = DIM_W'(j_q) == nm1;
	assign i_last = DIM_W'(i_q) == nm1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			n_q        <= DIM_W'(1);
			last_dim_q <= '0;
		end else if (start_compute) begin
			i_q        <= '0;
			j_q        <= '0;
			k_q        <= '0;
			n_q        <= active_dim;
			last_dim_q <= active_dim;
		end else if (issue) begin
			if (k_last) begin
				k_q <= '0;
				if (j_last) begin
					j_q <= '0;
					i_q <= i_q + IDX_W'(1);
				end else begin
					j_q <= j_q + IDX_W'(1);
				end
			end else begin
				k_q <= k_q + IDX_W'(1);
			end
		end
	end

	assign a_raddr      = ADDR_W'(ADDR_W'(i_q) * ADDR_W'(MAX_DIM) + ADDR_W'(k_q));
	assign b_raddr      = ADDR_W'(ADDR_W'(k_q) * ADDR_W'(MAX_DIM) + ADDR_W'(j_q));
	assign c_addr_issue = ADDR_W'(ADDR_W'(i_q) * ADDR_W'(MAX_DIM) + ADDR_W'(j_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_ctl <= '0;
		end else begin
			s1_ctl.vld  <= issue;
			s1_ctl.last <= issue & k_last;
		end
	end

	always_ff @(posedge clk) begin
		caddr_s1 <= c_addr_issue;
	end

	// ---------------- stores ----------------
	smme_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (DEPTH)
	) u_a_ram (
		.clk   (clk),
		.we    (in_acc && req == REQ_LOAD_A && in_store),
		.waddr (in_addr),
		.wdata (value_m),
		.re    (issue),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	smme_ram #(
		.WIDTH (VALUE_BITS),
		.DEPTH (DEPTH)
	) u_b_ram (
		.clk   (clk),
		.we    (in_acc && req == REQ_LOAD_B && in_store),
		.waddr (in_addr),
		.wdata (value_m),
		.re    (issue),
		.raddr (b_raddr),
		.rdata (b_rdata)
	);

	smme_ram #(
		.WIDTH (PRODUCT_W),
		.DEPTH (DEPTH)
	) u_c_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.re    (in_acc && req == REQ_READ),
		.raddr (in_addr),
		.rdata (c_rdata)
	);

	smme_mac #(
		.VALUE_BITS (VALUE_BITS),
		.ADDR_W     (ADDR_W)
	) u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s1   (s1_ctl),
		.caddr_s1 (caddr_s1),
		.a_data   (a_rdata),
		.b_data   (b_rdata),
		.c_we     (c_we),
		.c_waddr  (c_waddr),
		.c_wdata  (c_wdata)
	);

	// ---------------- output register ----------------
	// outside the last computed region (or the store) C reads as zero
	always_ff @(posedge clk) begin
		if (in_acc) begin
			zero_q <= (int'(row) >= int'(last_dim_q)) || (int'(col) >= int'(last_dim_q));
		end
		if (out_load) begin
			product_q <= zero_q ? '0 : c_rdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign product   = product_q;

	// ---------------- checks ----------------
	assign iter_ok = (DIM_W'(i_q) < n_q) && (DIM_W'(j_q) < n_q) && (DIM_W'(k_q) < n_q);

	`SMME_ASSERT(a_cwr_in_compute, clk, arst_n, c_we |-> (state_q == ST_COMPUTE || state_q == ST_DRAIN))
	`SMME_ASSERT(a_out_from_read, clk, arst_n, $rose(out_valid_q) |-> $past(state_q == ST_READ))
	`SMME_ASSERT(a_idle_pipe_empty, clk, arst_n, (state_q == ST_IDLE) |-> !s1_ctl.vld)
	`SMME_ASSERT(a_iter_in_range, clk, arst_n, (state_q == ST_COMPUTE) |-> iter_ok)
	`SMME_ASSERT_RST(a_rst_no_out, clk, !arst_n |-> !out_valid)

endmodule

`default_nettype wire
